// ===== rtl/lpg_pkg.sv =====
package lpg_pkg;

  localparam int WORD_W    = 31;
  localparam int POIS_W    = 4;
  localparam int POIS_MAX  = 15;
  localparam int MAX_COUNT = 11;
  localparam int TBL_LEN   = 16;
  localparam int TBL_IW    = $clog2(TBL_LEN);
  localparam int K_W       = $clog2(MAX_COUNT);
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = $clog2(WORD_W);
  localparam int THR_W     = 32;
  localparam int PROD_W    = 64;
  localparam int PART_W    = 2 * WORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 1'b1;

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  localparam logic [WORD_W-1:0] MULT_RST = WORD_W'(16807);
  localparam logic [WORD_W-1:0] MOD_RST  = WORD_W'(2147483647);
  localparam logic [WORD_W-1:0] Z_RST    = WORD_W'(1);

  // Poisson(1) cumulative probabilities, unsigned Q0.32
  localparam logic [THR_W-1:0] CDF_Q32 [TBL_LEN] = '{
    32'd1580030168, 32'd3160060337, 32'd3950075421, 32'd4213413783,
    32'd4279248373, 32'd4292415291, 32'd4294609777, 32'd4294923276,
    32'd4294962463, 32'd4294966817, 32'd4294967252, 32'd4294967292,
    32'd4294967295, 32'd4294967295, 32'd4294967295, 32'd4294967295
  };

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_QR_DIV  = 8'b0000_0010,
    ST_Z_DIV   = 8'b0000_0100,
    ST_MUL_A   = 8'b0000_1000,
    ST_MUL_R   = 8'b0001_0000,
    ST_FIX     = 8'b0010_0000,
    ST_CDF_MUL = 8'b0100_0000,
    ST_CDF_CMP = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/lehmer_poisson_generator_top.sv =====
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_ready  | in_opcode, in_seed
// out     | output    | out_valid / out_ready| out_uniform_word, out_poisson_count
// cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// A draw divides z by q on the bit-serial divider, forms the two partial products and
// the fold, then runs eleven threshold tests on the single 32x32 multiplier and goes
// back to idle. The first draw after reset or a register write first divides m by a.
// A reseed, or a draw with a degenerate register set, runs only the threshold tests.
// One word at a time; in_ready is low meanwhile. The last test stalls while the output
// register still holds an unaccepted word; a finished word waits there while the next
// is taken.
// Reset is synchronous, active low; state, configuration, seed and output valid reset.
module lehmer_poisson_generator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [lpg_pkg::WORD_W-1:0]       in_seed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lpg_pkg::WORD_W-1:0]       out_uniform_word,
  output logic [lpg_pkg::POIS_W-1:0]       out_poisson_count,
  input  logic                             cfg_we,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpg_pkg::WORD_W-1:0]       cfg_wdata
);
  import lpg_pkg::*;

  state_t              state_r, state_nxt;
  logic [WORD_W-1:0]   mult_r, mult_nxt;
  logic [WORD_W-1:0]   mod_r, mod_nxt;
  logic                dirty_r, dirty_nxt;
  logic [WORD_W-1:0]   q_r, q_nxt;
  logic [WORD_W-1:0]   rr_r, rr_nxt;
  logic [WORD_W-1:0]   z_r, z_nxt;
  logic [WORD_W-1:0]   lo_r, lo_nxt;
  logic [WORD_W-1:0]   hi_r, hi_nxt;
  logic [PART_W-1:0]   pa_r, pa_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;
  logic [POIS_W-1:0]   out_cnt_r, out_cnt_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [THR_W-1:0]    mul_a, mul_b;
  logic                degen;
  logic                borrow;
  logic [PART_W-1:0]   pb;
  logic [PROD_W-1:0]   lhs;
  logic                last_k;
  logic                out_free;

  lpg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign degen    = (mult_r == '0) || (mod_r == '0) || (mult_r > mod_r);
  assign pb       = prod_r[PART_W-1:0];
  assign borrow   = pa_r < pb;
  assign lhs      = {1'b0, z_r, 32'd0};
  assign last_k   = k_r == K_W'(MAX_COUNT - 1);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL_A: begin
        mul_a = THR_W'(mult_r);
        mul_b = THR_W'(lo_r);
      end
      ST_MUL_R: begin
        mul_a = THR_W'(rr_r);
        mul_b = THR_W'(hi_r);
      end
      // threshold product held steady while the compare waits
      ST_CDF_MUL, ST_CDF_CMP: begin
        mul_a = CDF_Q32[TBL_IW'(k_r)];
        mul_b = THR_W'(mod_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_nxt        = state_r;
    mult_nxt         = mult_r;
    mod_nxt          = mod_r;
    dirty_nxt        = dirty_r;
    q_nxt            = q_r;
    rr_nxt           = rr_r;
    z_nxt            = z_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    pa_nxt           = pa_r;
    k_nxt            = k_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_word_nxt     = out_word_r;
    out_cnt_nxt      = out_cnt_r;
    div_req.start    = 1'b0;
    div_req.dividend = z_r;
    div_req.divisor  = q_r;

    if (cfg_we) begin
      dirty_nxt = 1'b1;
      unique case (cfg_index)
        CFG_MULTIPLIER: mult_nxt = cfg_wdata;
        CFG_MODULUS:    mod_nxt  = cfg_wdata;
        default:        ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          k_nxt   = '0;
          cnt_nxt = '0;
          if (in_opcode == OP_RESEED) begin
            z_nxt     = in_seed;
            state_nxt = ST_CDF_MUL;
          end else if (degen) begin
            state_nxt = ST_CDF_MUL;
          end else if (dirty_r) begin
            div_req.start    = 1'b1;
            div_req.dividend = mod_r;
            div_req.divisor  = mult_r;
            state_nxt        = ST_QR_DIV;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = ST_Z_DIV;
          end
        end
      end
      ST_QR_DIV: begin
        if (div_rsp.done) begin
          q_nxt           = div_rsp.quo;
          rr_nxt          = div_rsp.rem;
          dirty_nxt       = cfg_we;
          div_req.start   = 1'b1;
          div_req.divisor = div_rsp.quo;
          state_nxt       = ST_Z_DIV;
        end
      end
      ST_Z_DIV: begin
        if (div_rsp.done) begin
          hi_nxt    = div_rsp.quo;
          lo_nxt    = div_rsp.rem;
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        pa_nxt    = prod_r[PART_W-1:0];
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        z_nxt     = WORD_W'(pa_r - pb) + (borrow ? mod_r : '0);
        state_nxt = ST_CDF_MUL;
      end
      ST_CDF_MUL: begin
        state_nxt = ST_CDF_CMP;
      end
      ST_CDF_CMP: begin
        if (last_k) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = z_r;
            if (lhs >= prod_r) begin
              out_cnt_nxt = (32'(cnt_r) + 32'd1 > 32'(POIS_MAX)) ?
                            POIS_W'(POIS_MAX) : POIS_W'(32'(cnt_r) + 32'd1);
            end else begin
              out_cnt_nxt = (32'(cnt_r) > 32'(POIS_MAX)) ?
                            POIS_W'(POIS_MAX) : POIS_W'(cnt_r);
            end
            state_nxt = ST_IDLE;
          end
        end else begin
          if (lhs >= prod_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_CDF_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mult_r      <= MULT_RST;
      mod_r       <= MOD_RST;
      dirty_r     <= 1'b1;
      z_r         <= Z_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mult_r      <= mult_nxt;
      mod_r       <= mod_nxt;
      dirty_r     <= dirty_nxt;
      z_r         <= z_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_r        <= q_nxt;
    rr_r       <= rr_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    pa_r       <= pa_nxt;
    prod_r     <= prod_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    out_word_r <= out_word_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_ready          = state_r == ST_IDLE;
  assign out_valid         = out_valid_r;
  assign out_uniform_word  = out_word_r;
  assign out_poisson_count = out_cnt_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_cnt_r) <= MAX_COUNT))
    else $error("poisson count above maximum");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_qr_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Z_DIV) && $past(state_r == ST_Z_DIV) |-> !$past(degen))
    else $error("draw divide with degenerate configuration");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_A) |-> !div_rsp.busy)
    else $error("divider still running after quotient taken");

endmodule

// ===== rtl/lpg_div.sv =====
module lpg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lpg_pkg::div_req_t req,
  output lpg_pkg::div_rsp_t rsp
);
  import lpg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [WORD_W-1:0]    quo_r, quo_nxt;
  logic [WORD_W-1:0]    dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W:0]      shifted;
  logic [WORD_W:0]      diff;
  logic                 ge;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[WORD_W-1]};
    ge       = shifted >= {1'b0, dsr_r};
    diff     = shifted - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = DIV_CNT_W'(WORD_W - 1);
    end else if (busy_r) begin
      rem_nxt = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== bench/lehmer_poisson_generator_top_test.sv =====
`timescale 1ns / 100ps

module lehmer_poisson_generator_top_test;

  localparam int W = lpg_pkg::WORD_W;
  localparam int CW = lpg_pkg::POIS_W;
  localparam int CUT_COUNT = 11;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 100;

  // Poisson(1) cumulative probabilities as Q0.32
  localparam bit [31:0] POISSON_CUT [CUT_COUNT] = '{
    32'd1580030168, 32'd3160060337, 32'd3950075421, 32'd4213413783,
    32'd4279248373, 32'd4292415291, 32'd4294609777, 32'd4294923276,
    32'd4294962463, 32'd4294966817, 32'd4294967252
  };

  typedef struct {
    logic [W-1:0]  word;
    logic [CW-1:0] count;
  } draw_t;

  class lehmer_draw_predictor;
    bit [W-1:0] mult;
    bit [W-1:0] modl;
    bit [W-1:0] z;
    draw_t expected_draws[$];
    int errors;

    function void reset();
      mult = W'(16807);
      modl = W'(2147483647);
      z = W'(1);
      expected_draws.delete();
      errors = 0;
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction

    // Schrage step, evaluated exactly in 64 bits
    function bit [W-1:0] schrage_step(bit [W-1:0] v);
      bit [63:0] a, m, q, r, lo, hi, pa, pb, t;
      a = 64'(mult);
      m = 64'(modl);
      if (a == 0 || m == 0 || a > m) return v;
      q = m / a;
      r = m % a;
      lo = 64'(v) % q;
      hi = 64'(v) / q;
      pa = a * lo;
      pb = r * hi;
      t = (pa >= pb) ? pa - pb : pa - pb + m;
      return t[W-1:0];
    endfunction

    function bit [CW-1:0] cdf_count(bit [W-1:0] v);
      bit [63:0] scaled;
      int n;
      scaled = {1'b0, v, 32'b0};
      n = 0;
      for (int k = 0; k < CUT_COUNT; k++)
        if (scaled >= 64'(POISSON_CUT[k]) * 64'(modl)) n++;
      return CW'(n);
    endfunction

    function void take_word(logic op, logic [W-1:0] seed);
      draw_t d;
      if (op == lpg_pkg::OP_RESEED) z = seed;
      else z = schrage_step(z);
      d.word = z;
      d.count = cdf_count(z);
      expected_draws.push_back(d);
    endfunction

    function void check_result(logic [W-1:0] word, logic [CW-1:0] count);
      draw_t d;
      if (expected_draws.size() == 0) begin
        $error("result word %0d arrived with none expected", word);
        errors++;
        return;
      end
      d = expected_draws.pop_front();
      if (word !== d.word) begin
        $error("uniform_word: expected %0d, actual %0d", d.word, word);
        errors++;
      end
      if (count !== d.count) begin
        $error("poisson_count: expected %0d, actual %0d", d.count, count);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_opcode = lpg_pkg::OP_DRAW;
  logic [W-1:0]  in_seed = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [W-1:0]  out_uniform_word;
  logic [CW-1:0] out_poisson_count;
  logic          cfg_we = 1'b0;
  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index = lpg_pkg::CFG_MULTIPLIER;
  logic [W-1:0]  cfg_wdata = '0;

  int send_idle_pct = 12;
  int recv_idle_pct = 63;

  lehmer_draw_predictor draws;

  lehmer_poisson_generator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_seed           (in_seed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_uniform_word  (out_uniform_word),
    .out_poisson_count (out_poisson_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      draws.check_result(out_uniform_word, out_poisson_count);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task send_word(logic op, logic [W-1:0] seed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_seed <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    draws.take_word(op, seed);
    @(negedge clk);
  endtask

  task hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (draws.pending() != 0) @(negedge clk);
  endtask

  task write_regs(logic [W-1:0] mult, logic [W-1:0] modl);
    hold_until_drained();
    cfg_we <= 1'b1;
    cfg_index <= lpg_pkg::CFG_MULTIPLIER;
    cfg_wdata <= mult;
    @(negedge clk);
    cfg_index <= lpg_pkg::CFG_MODULUS;
    cfg_wdata <= modl;
    @(negedge clk);
    cfg_we <= 1'b0;
    draws.mult = mult;
    draws.modl = modl;
  endtask

  function automatic logic [W-1:0] pick_seed();
    int sel;
    logic [W-1:0] m;
    sel = $urandom_range(0, 15);
    m = draws.modl;
    case (sel)
      0: return '0;
      1: return '1;
      2: return W'(1);
      3: return m - W'(1);
      4, 5: return W'($urandom);
      default: return (m > 2) ? W'($urandom_range(1, m - 1)) : W'(1);
    endcase
  endfunction

  task run_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) hold_until_drained();
      if ($urandom_range(0, 9) == 0) send_word(lpg_pkg::OP_RESEED, pick_seed());
      else send_word(lpg_pkg::OP_DRAW, W'($urandom));
    end
  endtask

  initial begin
    int unsigned a_r, m_r;
    draws = new();
    draws.reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration
    send_word(lpg_pkg::OP_DRAW, '0);
    send_word(lpg_pkg::OP_DRAW, '1);
    send_word(lpg_pkg::OP_RESEED, W'(2147483646));
    send_word(lpg_pkg::OP_DRAW, '0);
    send_word(lpg_pkg::OP_RESEED, W'(1));
    send_word(lpg_pkg::OP_RESEED, '0);
    send_word(lpg_pkg::OP_DRAW, '0);
    send_word(lpg_pkg::OP_RESEED, W'(2147483647));
    send_word(lpg_pkg::OP_DRAW, '0);

    // m = 2^30 puts values exactly on the first and last cut
    write_regs(W'(16807), W'(1073741824));
    send_word(lpg_pkg::OP_RESEED, W'(395007542));
    send_word(lpg_pkg::OP_RESEED, W'(395007541));
    send_word(lpg_pkg::OP_RESEED, W'(1073741813));
    send_word(lpg_pkg::OP_RESEED, W'(1073741812));
    send_word(lpg_pkg::OP_DRAW, '0);

    // r >= q
    write_regs(W'(2147483646), W'(2147483647));
    send_word(lpg_pkg::OP_RESEED, W'(12345));
    send_word(lpg_pkg::OP_DRAW, '0);
    send_word(lpg_pkg::OP_DRAW, '0);

    write_regs(W'(2), W'(3));
    send_word(lpg_pkg::OP_DRAW, '0);
    send_word(lpg_pkg::OP_DRAW, '0);

    // multiplier above modulus: value held
    write_regs(W'(1000), W'(500));
    send_word(lpg_pkg::OP_RESEED, W'(777));
    send_word(lpg_pkg::OP_DRAW, '0);

    // zero registers: value held, count saturates at the top
    write_regs('0, '0);
    send_word(lpg_pkg::OP_DRAW, '0);
    send_word(lpg_pkg::OP_RESEED, W'(5));
    send_word(lpg_pkg::OP_DRAW, '0);

    write_regs(W'(16807), W'(2147483647));
    send_word(lpg_pkg::OP_RESEED, W'(1));
    run_random(140);

    write_regs(W'(48271), W'(2147483647));
    run_random(140);

    send_idle_pct = 63;
    recv_idle_pct = 12;
    write_regs(W'(2), W'(3));
    run_random(140);

    a_r = $urandom_range(2, 46340);
    m_r = $urandom_range(a_r * a_r, 32'h7FFF_FFFF);
    write_regs(W'(a_r), W'(m_r));
    send_word(lpg_pkg::OP_RESEED, W'($urandom_range(1, m_r - 1)));
    run_random(140);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(W'(2147483646), W'(2147483647));
    run_random(140);

    m_r = $urandom_range(3, 32'h7FFF_FFFF);
    a_r = $urandom_range(2, m_r - 1);
    write_regs(W'(a_r), W'(m_r));
    send_word(lpg_pkg::OP_RESEED, W'($urandom_range(1, m_r - 1)));
    run_random(140);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (draws.errors == 0 && draws.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
